### design/assert_macros.svh
// Assertion macros used by the sampler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define LBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lbs_pkg.sv
// Types, constants and helper functions of the lattice bilinear sampler
`default_nettype none

package lbs_pkg;

  // Lattice geometry
  localparam int COL_BITS    = 6;
  localparam int ROW_BITS    = 6;
  localparam int MAX_COLUMNS = 1 << COL_BITS;
  localparam int MAX_ROWS    = 1 << ROW_BITS;
  localparam int COUNT_W     = COL_BITS + 1;

  // Four banks split by column and row parity, one corner from each
  localparam int BANK_AW    = (COL_BITS - 1) + (ROW_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;

  // Number formats
  localparam int POS_W     = 32;
  localparam int ELEV_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int QUO_W     = POS_W + FRAC_BITS;
  localparam int DIV_STEPS = QUO_W;
  localparam int U_W       = COL_BITS + 1 + FRAC_BITS;
  localparam int W_W       = FRAC_BITS + 1;

  // Field packing
  localparam int TDATA_W  = 112;
  localparam int CFG_IDX_W = 2;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Y = 2'd2;

  // Payload that travels with an item through the divider
  typedef struct packed {
    logic                query;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic [ELEV_W-1:0]   elev;
    logic                present;
    logic                neg_x;
    logic                neg_y;
  } item_t;

  // Divider state of one stage
  typedef struct packed {
    logic [POS_W-1:0] rem_x;
    logic [QUO_W-1:0] quo_x;
    logic [POS_W-1:0] mag_x;
    logic [POS_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_y;
    logic [POS_W-1:0] mag_y;
  } div_t;

  // One restoring step: returns {quotient bit, new remainder}
  function automatic logic [POS_W:0] div_step(input logic [POS_W-1:0] rem,
                                               input logic              bit_in,
                                               input logic [POS_W-1:0] dvsr);
    logic [POS_W:0] t;
    logic [POS_W:0] diff;
    t    = {rem, bit_in};
    diff = t - {1'b0, dvsr};
    if (t >= {1'b0, dvsr}) begin
      return {1'b1, diff[POS_W-1:0]};
    end else begin
      return {1'b0, t[POS_W-1:0]};
    end
  endfunction

  // Count limited to the stored lattice size
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    if (c > COUNT_W'(MAX_COLUMNS)) begin
      return COUNT_W'(MAX_COLUMNS);
    end else begin
      return c;
    end
  endfunction

endpackage

`default_nettype wire

### design/lattice_bilinear_sampler_core.sv
// Lattice bilinear sampler: vertex store and pipelined interpolating query path
// Path: input register, the 48-stage divider, then P1, P2, M, X1, X2, X3 and the output register.
// Throughput: one item per cycle; a stall on the result side halts the whole pipe.
// Reset: synchronous; clears pipeline valids and config, then a clearing pass
// sweeps every word of the four vertex banks, during which no item is taken.
// Config writes are taken in every cycle, also during the clearing pass.
`default_nettype none
`include "assert_macros.svh"

module lattice_bilinear_sampler_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // col[5:0], row[11:6], elevation_in[43:12], elevation_present[44],
  // pos_x[76:45], pos_y[108:77], zero fill above
  input  wire logic [lbs_pkg::TDATA_W-1:0]      s_tdata,
  input  wire logic [0:0]                       s_tuser,   // opcode[0]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  output logic [lbs_pkg::ELEV_W-1:0]            m_tdata,   // elevation_out[31:0]
  output logic [0:0]                            m_tuser,   // found[0]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  // Configuration registers
  logic [31:0]                  sample_spacing;
  logic [lbs_pkg::COUNT_W-1:0]  vertex_count_x;
  logic [lbs_pkg::COUNT_W-1:0]  vertex_count_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_spacing <= '0;
      vertex_count_x <= '0;
      vertex_count_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbs_pkg::CFG_SPACING: sample_spacing <= cfg_data;
        lbs_pkg::CFG_COUNT_X: vertex_count_x <= cfg_data[lbs_pkg::COUNT_W-1:0];
        lbs_pkg::CFG_COUNT_Y: vertex_count_y <= cfg_data[lbs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts
  logic [lbs_pkg::COUNT_W-1:0] cx;
  logic [lbs_pkg::COUNT_W-1:0] cy;
  logic [lbs_pkg::COUNT_W-1:0] cxm1;
  logic [lbs_pkg::COUNT_W-1:0] cym1;
  logic                        no_lattice;

  assign cx         = lbs_pkg::eff_count(vertex_count_x);
  assign cy         = lbs_pkg::eff_count(vertex_count_y);
  assign cxm1       = cx - lbs_pkg::COUNT_W'(1);
  assign cym1       = cy - lbs_pkg::COUNT_W'(1);
  assign no_lattice = (sample_spacing == '0) || (cx < lbs_pkg::COUNT_W'(2)) ||
                      (cy < lbs_pkg::COUNT_W'(2));

  // Clearing pass over the banks after reset
  logic [lbs_pkg::BANK_AW:0] clr_cnt;
  logic                      clearing;

  assign clearing = !clr_cnt[lbs_pkg::BANK_AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Global advance: the whole pipe moves unless a result is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !clearing;

  // Input unpacking
  logic [lbs_pkg::POS_W-1:0] in_px;
  logic [lbs_pkg::POS_W-1:0] in_py;
  lbs_pkg::item_t            in_item;

  assign in_px = s_tdata[76:45];
  assign in_py = s_tdata[108:77];

  always_comb begin
    in_item.query   = (s_tuser[0] == lbs_pkg::OP_QUERY);
    in_item.col     = s_tdata[5:0];
    in_item.row     = s_tdata[11:6];
    in_item.elev    = s_tdata[43:12];
    in_item.present = s_tdata[44];
    in_item.neg_x   = in_px[lbs_pkg::POS_W-1];
    in_item.neg_y   = in_py[lbs_pkg::POS_W-1];
  end

  // Divider pipe: stage 0 holds the input, each later stage one quotient bit
  lbs_pkg::item_t             pipe_item [lbs_pkg::DIV_STEPS+1];
  lbs_pkg::div_t              pipe_div  [lbs_pkg::DIV_STEPS+1];
  logic [lbs_pkg::DIV_STEPS:0] pipe_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= '0;
    end else if (en) begin
      pipe_vld <= {pipe_vld[lbs_pkg::DIV_STEPS-1:0], s_tvalid && !clearing};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_item[0]       <= in_item;
      pipe_div[0].rem_x  <= '0;
      pipe_div[0].quo_x  <= '0;
      pipe_div[0].mag_x  <= in_px[lbs_pkg::POS_W-1] ? (~in_px + 1'b1) : in_px;
      pipe_div[0].rem_y  <= '0;
      pipe_div[0].quo_y  <= '0;
      pipe_div[0].mag_y  <= in_py[lbs_pkg::POS_W-1] ? (~in_py + 1'b1) : in_py;
    end
  end

  // One restoring step per stage on both coordinates
  for (genvar k = 0; k < lbs_pkg::DIV_STEPS; k++) begin : g_div
    logic [lbs_pkg::POS_W:0] sx;
    logic [lbs_pkg::POS_W:0] sy;

    assign sx = lbs_pkg::div_step(pipe_div[k].rem_x,
                                  pipe_div[k].mag_x[lbs_pkg::POS_W-1], sample_spacing);
    assign sy = lbs_pkg::div_step(pipe_div[k].rem_y,
                                  pipe_div[k].mag_y[lbs_pkg::POS_W-1], sample_spacing);

    always_ff @(posedge clk) begin
      if (en) begin
        pipe_item[k+1]      <= pipe_item[k];
        pipe_div[k+1].rem_x <= sx[lbs_pkg::POS_W-1:0];
        pipe_div[k+1].quo_x <= {pipe_div[k].quo_x[lbs_pkg::QUO_W-2:0], sx[lbs_pkg::POS_W]};
        pipe_div[k+1].mag_x <= {pipe_div[k].mag_x[lbs_pkg::POS_W-2:0], 1'b0};
        pipe_div[k+1].rem_y <= sy[lbs_pkg::POS_W-1:0];
        pipe_div[k+1].quo_y <= {pipe_div[k].quo_y[lbs_pkg::QUO_W-2:0], sy[lbs_pkg::POS_W]};
        pipe_div[k+1].mag_y <= {pipe_div[k].mag_y[lbs_pkg::POS_W-2:0], 1'b0};
      end
    end
  end

  // P1: floor correction, range check and clamp
  localparam int LAST = lbs_pkg::DIV_STEPS;

  logic [lbs_pkg::U_W-1:0]   umax_x;
  logic [lbs_pkg::U_W-1:0]   umax_y;
  logic [lbs_pkg::QUO_W-1:0] umax_xw;
  logic [lbs_pkg::QUO_W-1:0] umax_yw;
  logic                      bad_x;
  logic                      bad_y;
  logic [lbs_pkg::U_W-1:0]   u_x_next;
  logic [lbs_pkg::U_W-1:0]   u_y_next;

  assign umax_x  = {cxm1, {lbs_pkg::FRAC_BITS{1'b0}}};
  assign umax_y  = {cym1, {lbs_pkg::FRAC_BITS{1'b0}}};
  assign umax_xw = lbs_pkg::QUO_W'(umax_x);
  assign umax_yw = lbs_pkg::QUO_W'(umax_y);

  always_comb begin
    // a negative quotient is -(q + inexact); only 0 and -1 step stay in range
    if (pipe_item[LAST].neg_x) begin
      bad_x    = (pipe_div[LAST].quo_x > lbs_pkg::QUO_W'(1)) ||
                 ((pipe_div[LAST].quo_x == lbs_pkg::QUO_W'(1)) &&
                  (pipe_div[LAST].rem_x != '0));
      u_x_next = '0;
    end else begin
      bad_x    = pipe_div[LAST].quo_x > (umax_xw + lbs_pkg::QUO_W'(1));
      u_x_next = (pipe_div[LAST].quo_x > umax_xw) ? umax_x :
                 pipe_div[LAST].quo_x[lbs_pkg::U_W-1:0];
    end
    if (pipe_item[LAST].neg_y) begin
      bad_y    = (pipe_div[LAST].quo_y > lbs_pkg::QUO_W'(1)) ||
                 ((pipe_div[LAST].quo_y == lbs_pkg::QUO_W'(1)) &&
                  (pipe_div[LAST].rem_y != '0));
      u_y_next = '0;
    end else begin
      bad_y    = pipe_div[LAST].quo_y > (umax_yw + lbs_pkg::QUO_W'(1));
      u_y_next = (pipe_div[LAST].quo_y > umax_yw) ? umax_y :
                 pipe_div[LAST].quo_y[lbs_pkg::U_W-1:0];
    end
  end

  logic                    p1_vld;
  lbs_pkg::item_t          p1_item;
  logic                    p1_miss;
  logic [lbs_pkg::U_W-1:0] p1_u;
  logic [lbs_pkg::U_W-1:0] p1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= pipe_vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_item <= pipe_item[LAST];
      p1_miss <= no_lattice || bad_x || bad_y;
      p1_u    <= u_x_next;
      p1_v    <= u_y_next;
    end
  end

  // P2: cell index and fraction; the far edge belongs to the last cell
  logic [lbs_pkg::COUNT_W-1:0] ihi;
  logic [lbs_pkg::COUNT_W-1:0] jhi;
  logic                        edge_x;
  logic                        edge_y;
  logic [lbs_pkg::COUNT_W-1:0] i_full;
  logic [lbs_pkg::COUNT_W-1:0] j_full;

  assign ihi    = p1_u[lbs_pkg::U_W-1:lbs_pkg::FRAC_BITS];
  assign jhi    = p1_v[lbs_pkg::U_W-1:lbs_pkg::FRAC_BITS];
  assign edge_x = (ihi == cxm1);
  assign edge_y = (jhi == cym1);
  assign i_full = edge_x ? (cxm1 - lbs_pkg::COUNT_W'(1)) : ihi;
  assign j_full = edge_y ? (cym1 - lbs_pkg::COUNT_W'(1)) : jhi;

  logic                         p2_vld;
  lbs_pkg::item_t               p2_item;
  logic                         p2_miss;
  logic [lbs_pkg::COL_BITS-1:0] p2_i;
  logic [lbs_pkg::ROW_BITS-1:0] p2_j;
  logic [lbs_pkg::W_W-1:0]      p2_fx;
  logic [lbs_pkg::W_W-1:0]      p2_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (en) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_item <= p1_item;
      p2_miss <= p1_miss;
      p2_i    <= i_full[lbs_pkg::COL_BITS-1:0];
      p2_j    <= j_full[lbs_pkg::ROW_BITS-1:0];
      p2_fx   <= edge_x ? lbs_pkg::W_W'(1 << lbs_pkg::FRAC_BITS) :
                 {1'b0, p1_u[lbs_pkg::FRAC_BITS-1:0]};
      p2_fy   <= edge_y ? lbs_pkg::W_W'(1 << lbs_pkg::FRAC_BITS) :
                 {1'b0, p1_v[lbs_pkg::FRAC_BITS-1:0]};
    end
  end

  // Vertex banks: bank {row parity, col parity}, word {valid, elevation}
  logic [lbs_pkg::BANK_AW-1:0] rd_addr [lbs_pkg::NUM_BANKS];
  logic [lbs_pkg::ELEV_W:0]    rd_data [lbs_pkg::NUM_BANKS];
  logic                        wr_en;
  logic [1:0]                  wr_bank;
  logic [lbs_pkg::BANK_AW-1:0] wr_addr;
  logic [lbs_pkg::ELEV_W:0]    wr_data;

  assign wr_en   = en && p2_vld && !p2_item.query;
  assign wr_bank = {p2_item.row[0], p2_item.col[0]};
  assign wr_addr = {p2_item.row[lbs_pkg::ROW_BITS-1:1], p2_item.col[lbs_pkg::COL_BITS-1:1]};
  assign wr_data = {p2_item.present, p2_item.elev};

  for (genvar b = 0; b < lbs_pkg::NUM_BANKS; b++) begin : g_bank
    logic [lbs_pkg::ELEV_W:0]      mem [lbs_pkg::BANK_DEPTH];
    logic [lbs_pkg::COL_BITS-1:0]  rc;
    logic [lbs_pkg::ROW_BITS-1:0]  rr;

    // pick whichever of the two neighbouring columns and rows has this parity
    assign rc = (p2_i[0] == b[0]) ? p2_i : (p2_i + 1'b1);
    assign rr = (p2_j[0] == b[1]) ? p2_j : (p2_j + 1'b1);
    assign rd_addr[b] = {rr[lbs_pkg::ROW_BITS-1:1], rc[lbs_pkg::COL_BITS-1:1]};

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_cnt[lbs_pkg::BANK_AW-1:0]] <= '0;
      end else if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (en) begin
        rd_data[b] <= mem[rd_addr[b]];
      end
    end
  end

  // M: read data arrives; only queries go on
  logic                    m_vld;
  logic                    m_miss;
  logic                    m_i0;
  logic                    m_j0;
  logic [lbs_pkg::W_W-1:0] m_fx;
  logic [lbs_pkg::W_W-1:0] m_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= p2_vld && p2_item.query;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_miss <= p2_miss;
      m_i0   <= p2_i[0];
      m_j0   <= p2_j[0];
      m_fx   <= p2_fx;
      m_fy   <= p2_fy;
    end
  end

  // X1: corner selection, valid check, horizontal weights
  logic [lbs_pkg::ELEV_W:0] c00;
  logic [lbs_pkg::ELEV_W:0] c10;
  logic [lbs_pkg::ELEV_W:0] c01;
  logic [lbs_pkg::ELEV_W:0] c11;
  logic [lbs_pkg::W_W-1:0]  wx0;
  logic [lbs_pkg::W_W-1:0]  wy0;

  assign c00 = rd_data[{m_j0, m_i0}];
  assign c10 = rd_data[{m_j0, !m_i0}];
  assign c01 = rd_data[{!m_j0, m_i0}];
  assign c11 = rd_data[{!m_j0, !m_i0}];
  assign wx0 = lbs_pkg::W_W'(1 << lbs_pkg::FRAC_BITS) - m_fx;

  logic               x1_vld;
  logic               x1_miss;
  logic signed [49:0] x1_p00;
  logic signed [49:0] x1_p10;
  logic signed [49:0] x1_p01;
  logic signed [49:0] x1_p11;
  logic [lbs_pkg::W_W-1:0] x1_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_vld <= 1'b0;
    end else if (en) begin
      x1_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_miss <= m_miss || !(c00[lbs_pkg::ELEV_W] && c10[lbs_pkg::ELEV_W] &&
                             c01[lbs_pkg::ELEV_W] && c11[lbs_pkg::ELEV_W]);
      x1_p00  <= $signed(c00[lbs_pkg::ELEV_W-1:0]) * $signed({1'b0, wx0});
      x1_p10  <= $signed(c10[lbs_pkg::ELEV_W-1:0]) * $signed({1'b0, m_fx});
      x1_p01  <= $signed(c01[lbs_pkg::ELEV_W-1:0]) * $signed({1'b0, wx0});
      x1_p11  <= $signed(c11[lbs_pkg::ELEV_W-1:0]) * $signed({1'b0, m_fx});
      x1_fy   <= m_fy;
    end
  end

  // X2: bottom and top edge blends
  logic               x2_vld;
  logic               x2_miss;
  logic signed [50:0] x2_bot;
  logic signed [50:0] x2_top;
  logic [lbs_pkg::W_W-1:0] x2_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      x2_vld <= 1'b0;
    end else if (en) begin
      x2_vld <= x1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_miss <= x1_miss;
      x2_bot  <= 51'(x1_p00) + 51'(x1_p10);
      x2_top  <= 51'(x1_p01) + 51'(x1_p11);
      x2_fy   <= x1_fy;
    end
  end

  // X3: vertical weights
  logic signed [68:0] tb_full;
  logic signed [68:0] tt_full;

  assign wy0     = lbs_pkg::W_W'(1 << lbs_pkg::FRAC_BITS) - x2_fy;
  assign tb_full = x2_bot * $signed({1'b0, wy0});
  assign tt_full = x2_top * $signed({1'b0, x2_fy});

  logic        x3_vld;
  logic        x3_miss;
  logic [63:0] x3_tb;
  logic [63:0] x3_tt;

  always_ff @(posedge clk) begin
    if (rst) begin
      x3_vld <= 1'b0;
    end else if (en) begin
      x3_vld <= x2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x3_miss <= x2_miss;
      x3_tb   <= tb_full[63:0];
      x3_tt   <= tt_full[63:0];
    end
  end

  // Output register: sum, round half up, drop 32 fractional bits
  logic [63:0] total_rnd;

  assign total_rnd = x3_tb + x3_tt + 64'h0000_0000_8000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= x3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= x3_miss ? '0 : total_rnd[63:32];
      m_tuser[0] <= !x3_miss;
    end
  end

  // Checks
  `LBS_ASSERT_NOW(a_no_take_while_clearing, clearing, !s_tready,
                  "item taken during bank clearing")
  `LBS_ASSERT_NEXT(a_clear_done_sticks, !clearing, !clearing,
                   "clearing pass restarted without reset")
  `LBS_ASSERT_NOW(a_miss_gives_zero, m_tvalid && !m_tuser[0], m_tdata == '0,
                  "result without a value is not zero")
  `LBS_ASSERT_NEXT(a_stall_holds_pipe, m_tvalid && !m_tready,
                   $stable(x3_vld) && $stable(pipe_vld),
                   "pipeline moved while the result was stalled")

endmodule

`default_nettype wire
